/* sv/kte_pkg.sv */
// Shared types and constants for the keypad time entry block.
package kte_pkg;

  localparam int DIGIT_COUNT = 6;

  // Keypad codes
  localparam logic [4:0] KEY_NONE = 5'd0;
  localparam logic [4:0] KEY_BACK = 5'd10;
  localparam logic [4:0] KEY_ZERO = 5'd11;

  // Cursor positions with a digit limit, and the end position
  localparam logic [2:0] POS_HOUR_TENS   = 3'd0;
  localparam logic [2:0] POS_HOUR_UNITS  = 3'd1;
  localparam logic [2:0] POS_MINUTE_TENS = 3'd2;
  localparam logic [2:0] POS_SECOND_TENS = 3'd4;
  localparam logic [2:0] POS_END         = 3'd6;

  // Digit limits
  localparam logic [3:0] HOUR_TENS_MAX     = 4'd2;
  localparam logic [3:0] HOUR_UNITS_MAX_20 = 4'd3;
  localparam logic [3:0] SIXTY_TENS_MAX    = 4'd5;

  typedef logic [DIGIT_COUNT-1:0][3:0] kte_digits_t;

  typedef struct packed {
    kte_digits_t digits;
    logic [2:0]  cursor;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
  } kte_state_t;

  typedef struct packed {
    logic        committed;
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hours;
    kte_digits_t digits;
    logic [2:0]  cursor;
  } kte_result_t;

endpackage

/* sv/kte_in_reg.sv */
// Input register stage holding one accepted key code.
module kte_in_reg import kte_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [4:0] in_key,
  input  logic       advance,
  output logic       in_ready,
  output logic       key_valid,
  output logic [4:0] key_code
);

  logic       valid_r, valid_nxt;
  logic [4:0] key_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      key_r <= in_key;
    end
  end

  assign key_valid = valid_r;
  assign key_code  = key_r;

endmodule

/* sv/kte_update.sv */
// Next-state and result logic for one key code.
module kte_update import kte_pkg::*; (
  input  kte_state_t  state,
  input  logic [4:0]  key_code,
  output kte_state_t  state_nxt,
  output kte_result_t result
);

  function automatic logic [6:0] pair_value(input logic [3:0] tens, input logic [3:0] units);
    logic [6:0] t;
    t = {3'b000, tens};
    return (t << 3) + (t << 1) + {3'b000, units};
  endfunction

  logic [2:0] cur;
  logic [3:0] digit;
  logic       allowed;
  logic       do_store;
  logic [3:0] store_val;
  logic       commit;
  logic [6:0] hour_pair, minute_pair, second_pair;

  assign cur   = (state.cursor > POS_END) ? POS_END : state.cursor;
  assign digit = key_code[3:0];

  always_comb begin
    allowed = 1'b1;
    if (cur == POS_HOUR_TENS && digit > HOUR_TENS_MAX) begin
      allowed = 1'b0;
    end
    if (cur == POS_HOUR_UNITS && state.digits[0] == HOUR_TENS_MAX
        && digit > HOUR_UNITS_MAX_20) begin
      allowed = 1'b0;
    end
    if ((cur == POS_MINUTE_TENS || cur == POS_SECOND_TENS) && digit > SIXTY_TENS_MAX) begin
      allowed = 1'b0;
    end
  end

  assign hour_pair   = pair_value(state.digits[0], state.digits[1]);
  assign minute_pair = pair_value(state.digits[2], state.digits[3]);
  assign second_pair = pair_value(state.digits[4], state.digits[5]);

  always_comb begin
    state_nxt        = state;
    state_nxt.cursor = cur;
    do_store         = 1'b0;
    store_val        = digit;
    commit           = 1'b0;
    priority if (key_code == KEY_NONE) begin
      // no key: nothing changes
    end else if (key_code < KEY_BACK) begin
      do_store = allowed;
    end else if (key_code == KEY_ZERO) begin
      do_store  = 1'b1;
      store_val = 4'd0;
    end else if (key_code == KEY_BACK) begin
      if (cur != 3'd0) begin
        state_nxt.cursor = cur - 3'd1;
      end
    end else begin
      commit            = 1'b1;
      state_nxt.hours   = hour_pair[4:0];
      state_nxt.minutes = minute_pair[5:0];
      state_nxt.seconds = second_pair[5:0];
      state_nxt.cursor  = 3'd0;
    end

    // cursor at end drops the write
    if (do_store && cur < POS_END) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        if (cur == 3'(i)) begin
          state_nxt.digits[i] = store_val;
        end
      end
      state_nxt.cursor = cur + 3'd1;
    end
  end

  always_comb begin
    result.committed = commit;
    result.seconds   = state_nxt.seconds;
    result.minutes   = state_nxt.minutes;
    result.hours     = state_nxt.hours;
    result.digits    = state_nxt.digits;
    result.cursor    = state_nxt.cursor;
  end

endmodule

/* sv/keypad_time_entry_core.sv */
// Top level of the keypad time entry block.
// Keypad time entry: each input transaction carries one keypad code and
// produces exactly one output transaction showing the edit cursor, the six
// stored HHMMSS digits and the last committed hours/minutes/seconds, all
// after the update. Codes: 0 no key, 1-9 digit (range-checked per
// position), 10 back, 11 zero, 12 and above commit (committed flag set in
// out_tuser). The key sits in the input register after its transaction,
// and when the result register is free it runs through the update logic
// into the state and result registers, where out_tvalid rises. Throughput
// is one key per cycle while out_tready does not stall the result
// register. The result register frees as its transaction completes, so a
// new key moves forward in the same cycle.
// Reset clears the digits, cursor and committed values to zero.
module keypad_time_entry_core import kte_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [4:0] key_code, [7:5] zero
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] cursor, [6:3] hour_tens, [10:7] hour_units, [14:11] minute_tens,
  // [18:15] minute_units, [22:19] second_tens, [26:23] second_units,
  // [31:27] hours, [37:32] minutes, [43:38] seconds, [47:44] zero
  output logic [47:0] out_tdata,
  output logic        out_tuser   // committed
);

  logic        key_valid;
  logic [4:0]  key_code;
  logic        advance;

  kte_state_t  state_r, state_nxt;
  kte_result_t result;
  kte_result_t res_r;
  logic        out_valid_r, out_valid_nxt;

  // move a key through the update when the result register is free
  assign advance = key_valid && (!out_valid_r || out_tready);

  kte_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_key    (in_tdata[4:0]),
    .advance   (advance),
    .in_ready  (in_tready),
    .key_valid (key_valid),
    .key_code  (key_code)
  );

  kte_update u_update (
    .state     (state_r),
    .key_code  (key_code),
    .state_nxt (state_nxt),
    .result    (result)
  );

  always_comb begin
    priority if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // time state is architectural: cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, res_r.seconds, res_r.minutes, res_r.hours,
                       res_r.digits, res_r.cursor};
  assign out_tuser  = res_r.committed;

endmodule

/* sv/kte_checker.sv */
// Port-level checker for the keypad time entry block, with its bind.
module kte_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tuser
);

  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // cursor never beyond the end position
  a_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= 3'd6)
    else $error("cursor out of range");

  // a commit returns the cursor to the first digit
  a_commit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[2:0] == 3'd0)
    else $error("commit left cursor off start");

  // digit limits keep the committed values in range
  a_values: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:27] <= 5'd29 && out_tdata[37:32] <= 6'd59
                   && out_tdata[43:38] <= 6'd59)
    else $error("committed value out of range");

endmodule

bind keypad_time_entry_core kte_checker u_kte_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
